// File: sv/cht_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cht_pkg
// Shared types, constants, microcode and saturation helpers for the cubic
// Hermite trajectory generator.
// ---------------------------------------------------------------------------
package cht_pkg;

  // fixed-point format
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int DT_W      = 16;
  localparam int COEF_W    = 36;
  localparam int ACC_W     = 48;
  localparam int HALF_W    = ACC_W / 2;
  localparam int MUL_A_W   = HALF_W + 1;
  localparam int MUL_B_W   = DATA_W + 1;
  localparam int MUL_W     = MUL_A_W + MUL_B_W;
  localparam int PROD_W    = ACC_W + MUL_B_W;
  localparam int SUM_W     = ACC_W + 1;
  localparam int STEP_W    = 4;

  // configuration register indexes
  localparam logic [1:0] REG_START_POS = 2'd0;
  localparam logic [1:0] REG_GOAL_POS  = 2'd1;
  localparam logic [1:0] REG_START_VEL = 2'd2;
  localparam logic [1:0] REG_GOAL_VEL  = 2'd3;

  // request opcodes
  localparam logic OP_LATCH  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // accumulator operations of a control word
  localparam logic [2:0] ACC_NOP    = 3'd0;
  localparam logic [2:0] ACC_LOAD   = 3'd1;
  localparam logic [2:0] ACC_HORNER = 3'd2;
  localparam logic [2:0] ACC_FINAL  = 3'd3;
  localparam logic [2:0] ACC_LATCH  = 3'd4;

  // coefficient selects
  localparam logic [1:0] COEF_0 = 2'd0;
  localparam logic [1:0] COEF_1 = 2'd1;
  localparam logic [1:0] COEF_2 = 2'd2;
  localparam logic [1:0] COEF_3 = 2'd3;

  // microprogram entry points
  localparam logic [STEP_W-1:0] STEP_DISPATCH = 4'd0;
  localparam logic [STEP_W-1:0] STEP_LATCH    = 4'd10;

  localparam logic signed [ACC_W-1:0]  ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0]  ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] POS_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // one microcode control word
  typedef struct packed {
    logic              done;
    logic              jump_latch;
    logic [STEP_W-1:0] target;
    logic              mul_en;
    logic              mul_hi;
    logic [2:0]        acc_op;
    logic [1:0]        coef_sel;
  } ctrl_word_t;

  // status from datapath to sequencer
  typedef struct packed {
    logic op;
  } dp_status_t;

  // one result
  typedef struct packed {
    logic signed [DATA_W-1:0] position;
    logic                     spline_ready;
    logic                     saturated;
  } result_t;

  // microprogram rom: horner evaluation in three multiply-add rounds
  function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w = '0;
    unique case (step)
      STEP_DISPATCH: begin
        w.acc_op     = ACC_LOAD;
        w.coef_sel   = COEF_3;
        w.jump_latch = 1'b1;
        w.target     = STEP_LATCH;
      end
      4'd1, 4'd4, 4'd7: begin
        w.mul_en = 1'b1;
        w.mul_hi = 1'b0;
      end
      4'd2, 4'd5, 4'd8: begin
        w.mul_en = 1'b1;
        w.mul_hi = 1'b1;
      end
      4'd3: begin
        w.acc_op   = ACC_HORNER;
        w.coef_sel = COEF_2;
      end
      4'd6: begin
        w.acc_op   = ACC_HORNER;
        w.coef_sel = COEF_1;
      end
      4'd9: begin
        w.acc_op   = ACC_FINAL;
        w.coef_sel = COEF_0;
        w.done     = 1'b1;
      end
      STEP_LATCH: begin
        w.acc_op = ACC_LATCH;
        w.done   = 1'b1;
      end
      default: begin
        w.done = 1'b1;
      end
    endcase
    return w;
  endfunction

  // floor of the product by 2^FRAC_BITS, clamped to the accumulator range
  function automatic logic signed [ACC_W-1:0] scale_sat(
    input logic signed [PROD_W-1:0] p
  );
    logic signed [PROD_W-1:0] s;
    s = p >>> FRAC_BITS;
    if (s > PROD_W'(ACC_MAX)) begin
      return ACC_MAX;
    end else if (s < PROD_W'(ACC_MIN)) begin
      return ACC_MIN;
    end
    return s[ACC_W-1:0];
  endfunction

  // add a coefficient and clamp to the accumulator range
  function automatic logic signed [ACC_W-1:0] add_sat(
    input logic signed [ACC_W-1:0]  a,
    input logic signed [COEF_W-1:0] c
  );
    logic signed [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(c);
    if (s > SUM_W'(ACC_MAX)) begin
      return ACC_MAX;
    end else if (s < SUM_W'(ACC_MIN)) begin
      return ACC_MIN;
    end
    return s[ACC_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: sv/cubic_hermite_trajectory.sv
`timescale 1ns / 1ps
`default_nettype none
// Sample request: the microprogram runs three rounds on one shared
// 25x33 multiplier (low half, high half, scale and add per round) and
// loads the result register; a new request may enter on the finishing step.
// Latch request: the dispatch step, then the latch step.
// Reset clears configuration registers, coefficients, spline time and the ready flag.
// ---------------------------------------------------------------------------
// cubic_hermite_trajectory
// Cubic Hermite spline setpoint generator: microcoded sequencer over a
// Horner-evaluation datapath, with a registered result stage.
// ---------------------------------------------------------------------------
module cubic_hermite_trajectory (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_wr_en,
  input  wire  [1:0]                        cfg_index,
  input  wire  [cht_pkg::DATA_W-1:0]        cfg_data,
  input  wire                               item_valid,
  output logic                              item_stall,
  input  wire                               op,
  input  wire  [cht_pkg::DT_W-1:0]          time_step,
  output logic                              result_valid,
  input  wire                               result_stall,
  output logic signed [cht_pkg::DATA_W-1:0] position,
  output logic                              spline_ready,
  output logic                              saturated
);

  cht_pkg::ctrl_word_t ctrl;
  cht_pkg::dp_status_t status;
  cht_pkg::result_t    result;
  logic                fire;
  logic                busy;
  logic                finish;
  logic                start;
  logic                hold;

  // request handshake: a new request may enter on the finishing step
  assign item_stall = busy & ~finish;
  assign start      = item_valid & ~item_stall;
  assign hold       = result_valid & result_stall;

  cht_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .hold   (hold),
    .status (status),
    .ctrl   (ctrl),
    .fire   (fire),
    .busy   (busy),
    .finish (finish)
  );

  cht_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .start     (start),
    .op        (op),
    .time_step (time_step),
    .ctrl      (ctrl),
    .fire      (fire),
    .status    (status),
    .result    (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (finish) begin
      result_valid <= 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      position     <= result.position;
      spline_ready <= result.spline_ready;
      saturated    <= result.saturated;
    end
  end

endmodule

`default_nettype wire

// File: sv/cht_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cht_sequencer
// Step counter over the microcode rom, with the opcode jump and a hold on
// the final step while the result register is still occupied.
// ---------------------------------------------------------------------------
module cht_sequencer (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  wire                 hold,
  input  cht_pkg::dp_status_t status,
  output cht_pkg::ctrl_word_t ctrl,
  output logic                fire,
  output logic                busy,
  output logic                finish
);

  logic [cht_pkg::STEP_W-1:0] step;
  logic [cht_pkg::STEP_W-1:0] step_next;
  logic                       busy_next;

  // fetch the current control word
  assign ctrl   = cht_pkg::ucode(step);
  assign fire   = busy & ~(ctrl.done & hold);
  assign finish = fire & ctrl.done;

  // next step selection
  always_comb begin
    step_next = step;
    busy_next = busy;
    if (start) begin
      step_next = cht_pkg::STEP_DISPATCH;
      busy_next = 1'b1;
    end else if (fire) begin
      if (ctrl.done) begin
        busy_next = 1'b0;
      end else if (ctrl.jump_latch && (status.op == cht_pkg::OP_LATCH)) begin
        step_next = ctrl.target;
      end else begin
        step_next = step + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= cht_pkg::STEP_DISPATCH;
      busy <= 1'b0;
    end else begin
      step <= step_next;
      busy <= busy_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/cht_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// cht_datapath
// Configuration registers, coefficient store, spline time, a shared
// half-width multiplier and the Horner accumulator.
// ---------------------------------------------------------------------------
module cht_datapath (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_wr_en,
  input  wire  [1:0]                        cfg_index,
  input  wire  [cht_pkg::DATA_W-1:0]        cfg_data,
  input  wire                               start,
  input  wire                               op,
  input  wire  [cht_pkg::DT_W-1:0]          time_step,
  input  cht_pkg::ctrl_word_t               ctrl,
  input  wire                               fire,
  output cht_pkg::dp_status_t               status,
  output cht_pkg::result_t                  result
);

  localparam int DW = cht_pkg::DATA_W;
  localparam int CW = cht_pkg::COEF_W;
  localparam int AW = cht_pkg::ACC_W;
  localparam int HW = cht_pkg::HALF_W;
  localparam int PW = cht_pkg::PROD_W;

  logic signed [DW-1:0] start_pos;
  logic signed [DW-1:0] goal_pos;
  logic signed [DW-1:0] start_vel;
  logic signed [DW-1:0] goal_vel;

  logic signed [CW-1:0] coef0;
  logic signed [CW-1:0] coef1;
  logic signed [CW-1:0] coef2;
  logic signed [CW-1:0] coef3;
  logic                 ready_flag;
  logic [DW-1:0]        spline_clock;

  logic                 op_q;
  logic [cht_pkg::DT_W-1:0] dt_q;

  logic signed [AW-1:0] acc;
  logic signed [PW-1:0] prod;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      start_pos <= '0;
      goal_pos  <= '0;
      start_vel <= '0;
      goal_vel  <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        cht_pkg::REG_START_POS: start_pos <= cfg_data;
        cht_pkg::REG_GOAL_POS:  goal_pos  <= cfg_data;
        cht_pkg::REG_START_VEL: start_vel <= cfg_data;
        cht_pkg::REG_GOAL_VEL:  goal_vel  <= cfg_data;
        default: ;
      endcase
    end
  end

  // request fields held for the length of the program
  always_ff @(posedge clk) begin
    if (start) begin
      op_q <= op;
      dt_q <= time_step;
    end
  end

  assign status.op = op_q;

  // coefficients from the boundary conditions
  logic signed [CW-1:0] p0_x;
  logic signed [CW-1:0] pg_x;
  logic signed [CW-1:0] v0_x;
  logic signed [CW-1:0] vg_x;
  logic signed [CW-1:0] dpos;
  logic signed [CW-1:0] c2_new;
  logic signed [CW-1:0] c3_new;

  always_comb begin
    p0_x   = CW'(start_pos);
    pg_x   = CW'(goal_pos);
    v0_x   = CW'(start_vel);
    vg_x   = CW'(goal_vel);
    dpos   = pg_x - p0_x;
    c2_new = (dpos <<< 1) + dpos - (v0_x <<< 1) - vg_x;
    c3_new = v0_x + vg_x - (dpos <<< 1);
  end

  // coefficient select
  logic signed [CW-1:0] coef_sel;

  always_comb begin
    case (ctrl.coef_sel)
      cht_pkg::COEF_0: coef_sel = coef0;
      cht_pkg::COEF_1: coef_sel = coef1;
      cht_pkg::COEF_2: coef_sel = coef2;
      default:         coef_sel = coef3;
    endcase
  end

  // shared multiplier: one accumulator half times the spline time
  logic signed [cht_pkg::MUL_A_W-1:0] mul_a;
  logic signed [cht_pkg::MUL_B_W-1:0] mul_b;
  logic signed [cht_pkg::MUL_W-1:0]   mul_p;

  always_comb begin
    if (ctrl.mul_hi) begin
      // upper half carries the sign of the accumulator
      mul_a = {acc[AW-1], acc[AW-1:HW]};
    end else begin
      mul_a = {1'b0, acc[HW-1:0]};
    end
    mul_b = {1'b0, spline_clock};
    mul_p = mul_a * mul_b;
  end

  // product accumulation over the two halves
  always_ff @(posedge clk) begin
    if (fire && ctrl.mul_en) begin
      if (ctrl.mul_hi) begin
        prod <= prod + (PW'(mul_p) <<< HW);
      end else begin
        prod <= PW'(mul_p);
      end
    end
  end

  // horner step and final position
  logic signed [AW-1:0]           scaled;
  logic signed [cht_pkg::SUM_W-1:0] pos_sum;
  logic signed [DW-1:0]           pos_val;
  logic                           pos_sat;
  logic [DW:0]                    clock_sum;

  always_comb begin
    scaled  = cht_pkg::scale_sat(prod);
    pos_sum = cht_pkg::SUM_W'(scaled) + cht_pkg::SUM_W'(coef0);
    pos_sat = 1'b0;
    pos_val = pos_sum[DW-1:0];
    if (pos_sum > cht_pkg::SUM_W'(cht_pkg::POS_MAX)) begin
      pos_val = cht_pkg::POS_MAX;
      pos_sat = 1'b1;
    end else if (pos_sum < cht_pkg::SUM_W'(cht_pkg::POS_MIN)) begin
      pos_val = cht_pkg::POS_MIN;
      pos_sat = 1'b1;
    end
    clock_sum = {1'b0, spline_clock} + (DW+1)'(dt_q);
  end

  // accumulator and spline state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      coef0        <= '0;
      coef1        <= '0;
      coef2        <= '0;
      coef3        <= '0;
      ready_flag   <= 1'b0;
      spline_clock <= '0;
    end else if (fire) begin
      unique case (ctrl.acc_op)
        cht_pkg::ACC_LOAD: begin
          acc <= AW'(coef_sel);
        end
        cht_pkg::ACC_HORNER: begin
          acc <= cht_pkg::add_sat(scaled, coef_sel);
        end
        cht_pkg::ACC_FINAL: begin
          if (clock_sum[DW]) begin
            spline_clock <= '1;
          end else begin
            spline_clock <= clock_sum[DW-1:0];
          end
        end
        cht_pkg::ACC_LATCH: begin
          coef0      <= p0_x;
          coef1      <= v0_x;
          coef2      <= c2_new;
          coef3      <= c3_new;
          ready_flag <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // result of the finishing step
  always_comb begin
    if (ctrl.acc_op == cht_pkg::ACC_LATCH) begin
      result.position     = '0;
      result.spline_ready = 1'b1;
      result.saturated    = 1'b0;
    end else begin
      result.position     = pos_val;
      result.spline_ready = ready_flag;
      result.saturated    = pos_sat;
    end
  end

endmodule

`default_nettype wire

// File: test/trajectory_monitor.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// trajectory_monitor
// Watches the register port, the request channel and the result channel of
// the trajectory generator. Keeps its own copy of the setpoint registers,
// spline coefficients, spline time and ready flag, predicts each setpoint
// and compares every accepted result, in order, against the oldest one due.
// ---------------------------------------------------------------------------
module trajectory_monitor (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_wr_en,
  input  wire  [1:0]                        cfg_index,
  input  wire  [cht_pkg::DATA_W-1:0]        cfg_data,
  input  wire                               item_valid,
  input  wire                               item_stall,
  input  wire                               op,
  input  wire  [cht_pkg::DT_W-1:0]          time_step,
  input  wire                               result_valid,
  input  wire                               result_stall,
  input  wire  signed [cht_pkg::DATA_W-1:0] position,
  input  wire                               spline_ready,
  input  wire                               saturated,
  output int                                failures,
  output int                                pending
);

  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint POS_HI = 64'sh0000_0000_7FFF_FFFF;
  localparam longint POS_LO = -POS_HI - 1;
  localparam logic [31:0] TIME_END = 32'hFFFF_FFFF;

  logic [cht_pkg::DATA_W-1:0] setpoint_regs [4];
  longint                     spline_coef [4];
  logic [31:0]                t_now;
  logic                       ready;
  cht_pkg::result_t           expected_setpoints [$];
  int                         fail_total = 0;

  // floor(a * t / 2^FRAC_BITS), clamped to the accumulator range
  function automatic longint time_product(input longint a, input logic [31:0] t);
    logic signed [95:0] wide_a;
    logic signed [95:0] wide_t;
    logic signed [95:0] prod;
    wide_a = 96'(a);
    wide_t = $signed({64'd0, t});
    prod = (wide_a * wide_t) >>> cht_pkg::FRAC_BITS;
    if (prod > ACC_HI) return ACC_HI;
    if (prod < ACC_LO) return ACC_LO;
    return longint'(prod);
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // horner evaluation of the cubic at the current spline time
  function automatic cht_pkg::result_t sample_setpoint();
    cht_pkg::result_t r;
    longint           acc;
    acc = clamp(time_product(spline_coef[3], t_now) + spline_coef[2], ACC_LO, ACC_HI);
    acc = clamp(time_product(acc, t_now) + spline_coef[1], ACC_LO, ACC_HI);
    acc = time_product(acc, t_now) + spline_coef[0];
    r.position     = cht_pkg::DATA_W'(clamp(acc, POS_LO, POS_HI));
    r.saturated    = (acc > POS_HI) || (acc < POS_LO);
    r.spline_ready = ready;
    return r;
  endfunction

  task automatic compare_field(input string field, input longint want, input longint got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, want, got);
      fail_total++;
    end
  endtask

  always @(posedge clk) begin
    cht_pkg::result_t predicted;
    cht_pkg::result_t oldest;
    longint           p0, pg, v0, vg;
    logic [32:0]      next_time;
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        setpoint_regs[i] = '0;
        spline_coef[i]   = 0;
      end
      t_now = '0;
      ready = 1'b0;
      expected_setpoints.delete();
    end else begin
      // register writes
      if (cfg_wr_en) begin
        setpoint_regs[cfg_index] = cfg_data;
      end
      // accepted request: predict its setpoint
      if (item_valid && !item_stall) begin
        if (op == cht_pkg::OP_LATCH) begin
          p0 = longint'($signed(setpoint_regs[cht_pkg::REG_START_POS]));
          pg = longint'($signed(setpoint_regs[cht_pkg::REG_GOAL_POS]));
          v0 = longint'($signed(setpoint_regs[cht_pkg::REG_START_VEL]));
          vg = longint'($signed(setpoint_regs[cht_pkg::REG_GOAL_VEL]));
          spline_coef[0] = p0;
          spline_coef[1] = v0;
          spline_coef[2] = 3 * (pg - p0) - 2 * v0 - vg;
          spline_coef[3] = 2 * (p0 - pg) + v0 + vg;
          ready = 1'b1;
          predicted = '0;
          predicted.spline_ready = 1'b1;
        end else begin
          predicted = sample_setpoint();
          // spline time stops at its top value
          next_time = {1'b0, t_now} + 33'(time_step);
          t_now = next_time[32] ? TIME_END : next_time[31:0];
        end
        expected_setpoints.push_back(predicted);
      end
      // accepted result: compare with the oldest prediction
      if (result_valid && !result_stall) begin
        if (expected_setpoints.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual position %0d ready %0b sat %0b",
                   $time, position, spline_ready, saturated);
          fail_total++;
        end else begin
          oldest = expected_setpoints.pop_front();
          compare_field("position", oldest.position, position);
          compare_field("spline_ready", oldest.spline_ready, spline_ready);
          compare_field("saturated", oldest.saturated, saturated);
        end
      end
    end
    failures <= fail_total;
    pending  <= expected_setpoints.size();
  end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Drives the cubic Hermite trajectory generator: directed corner cases, then
// phases of register setup, coefficient latch and random samples with random
// idling on both channels, then a run of full time steps and a flat spline.
// Checking is done by the monitor beside the block.
// ---------------------------------------------------------------------------
module testbench;

  localparam int RANDOM_ITEMS   = 1080;
  localparam int STEADY_ITEMS   = 150;
  localparam int RUNOUT_SAMPLES = 40;
  localparam int SETTLE_CYCLES  = 12;
  localparam int STALL_LIMIT    = 4000;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_wr_en = 1'b0;
  logic [1:0]                 cfg_index = '0;
  logic [cht_pkg::DATA_W-1:0] cfg_data = '0;
  logic                       item_valid = 1'b0;
  logic                       item_stall;
  logic                       op = 1'b0;
  logic [cht_pkg::DT_W-1:0]   time_step = '0;
  logic                       result_valid;
  logic                       result_stall = 1'b0;
  logic signed [cht_pkg::DATA_W-1:0] position;
  logic                       spline_ready;
  logic                       saturated;

  int   failures;
  int   pending;
  int   idle_rate = 2;
  int   stall_rate = 2;
  logic steady = 1'b0;
  int   stall_left = 0;
  int   idle_cycles = 0;
  int   items_sent = 0;

  always #10 clk = ~clk;

  cubic_hermite_trajectory dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .op           (op),
    .time_step    (time_step),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .position     (position),
    .spline_ready (spline_ready),
    .saturated    (saturated)
  );

  trajectory_monitor traj_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .op           (op),
    .time_step    (time_step),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .position     (position),
    .spline_ready (spline_ready),
    .saturated    (saturated),
    .failures     (failures),
    .pending      (pending)
  );

  // random result side stall bursts
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left   <= 0;
    end else if (stall_left != 0) begin
      stall_left   <= stall_left - 1;
      result_stall <= 1'b1;
    end else if (!steady && stall_rate != 0 && $urandom_range(0, 7) < stall_rate) begin
      stall_left   <= $urandom_range(0, 11);
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  // watchdog on cycles with no traffic at all
  always @(posedge clk) begin
    if (rst || cfg_wr_en || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // setpoint register values, weighted toward extremes and small magnitudes
  function automatic logic [cht_pkg::DATA_W-1:0] random_setpoint();
    case ($urandom_range(0, 7))
      0: return cht_pkg::POS_MAX;
      1: return cht_pkg::POS_MIN;
      2: return '0;
      3, 4: return cht_pkg::DATA_W'($urandom_range(0, 128)) - cht_pkg::DATA_W'(64);
      5: return cht_pkg::DATA_W'($urandom_range(0, 32'h3FFFF)) - cht_pkg::DATA_W'(32'h20000);
      default: return $urandom();
    endcase
  endfunction

  // time steps, mostly small so the spline time grows slowly
  function automatic logic [cht_pkg::DT_W-1:0] random_time_step();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4, 5: return cht_pkg::DT_W'($urandom_range(0, 255));
      6, 7: return cht_pkg::DT_W'($urandom_range(0, 4095));
      default: return cht_pkg::DT_W'($urandom());
    endcase
  endfunction

  // one request, with an optional idle burst ahead of it; valid stays high
  // after acceptance, so the caller drives it again in that same step
  task automatic send_request(input logic req_op, input logic [cht_pkg::DT_W-1:0] dt);
    int gap;
    if (!steady && idle_rate != 0 && $urandom_range(0, 7) < idle_rate) begin
      gap = $urandom_range(1, 12);
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    op         <= req_op;
    time_step  <= dt;
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  // wait until every setpoint has come back and the block has settled
  task automatic wait_drained();
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [1:0] index,
                                input logic [cht_pkg::DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  // load all four setpoint registers while the block is idle
  task automatic program_setpoints(input logic [cht_pkg::DATA_W-1:0] start_pos,
                                   input logic [cht_pkg::DATA_W-1:0] goal_pos,
                                   input logic [cht_pkg::DATA_W-1:0] start_vel,
                                   input logic [cht_pkg::DATA_W-1:0] goal_vel);
    item_valid <= 1'b0;
    wait_drained();
    write_register(cht_pkg::REG_START_POS, start_pos);
    write_register(cht_pkg::REG_GOAL_POS, goal_pos);
    write_register(cht_pkg::REG_START_VEL, start_vel);
    write_register(cht_pkg::REG_GOAL_VEL, goal_vel);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    int                         phase_len;
    logic [cht_pkg::DATA_W-1:0] anchor;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // sampling before any latch gives zero
    send_request(cht_pkg::OP_SAMPLE, '0);
    send_request(cht_pkg::OP_SAMPLE, '1);

    // largest coefficients of both signs
    program_setpoints(cht_pkg::POS_MAX, cht_pkg::POS_MIN, cht_pkg::POS_MAX, cht_pkg::POS_MIN);
    send_request(cht_pkg::OP_LATCH, cht_pkg::DT_W'($urandom()));
    send_request(cht_pkg::OP_SAMPLE, '0);
    send_request(cht_pkg::OP_SAMPLE, cht_pkg::DT_W'(1));
    send_request(cht_pkg::OP_SAMPLE, '1);
    program_setpoints(cht_pkg::POS_MIN, cht_pkg::POS_MAX, cht_pkg::POS_MIN, cht_pkg::POS_MAX);
    send_request(cht_pkg::OP_LATCH, '1);
    send_request(cht_pkg::OP_SAMPLE, cht_pkg::DT_W'(16'h8000));
    send_request(cht_pkg::OP_SAMPLE, '0);

    // moderate spline, latched twice in a row
    program_setpoints(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 32'hFFFF_8000);
    send_request(cht_pkg::OP_LATCH, '0);
    send_request(cht_pkg::OP_LATCH, '0);
    repeat (3) send_request(cht_pkg::OP_SAMPLE, random_time_step());

    // random phases: set up, latch, then a run of samples
    while (items_sent < RANDOM_ITEMS) begin
      if (items_sent >= RANDOM_ITEMS - STEADY_ITEMS) begin
        steady <= 1'b1;
      end else begin
        idle_rate = $urandom_range(0, 3);
        stall_rate <= $urandom_range(0, 3);
      end
      program_setpoints(random_setpoint(), random_setpoint(),
                        random_setpoint(), random_setpoint());
      // now and then the samples run on the old coefficients
      if ($urandom_range(0, 7) != 0) begin
        send_request(cht_pkg::OP_LATCH, cht_pkg::DT_W'($urandom()));
      end
      phase_len = $urandom_range(4, 40);
      repeat (phase_len) begin
        if ($urandom_range(0, 19) == 0) begin
          send_request(cht_pkg::OP_LATCH, cht_pkg::DT_W'($urandom()));
        end else begin
          send_request(cht_pkg::OP_SAMPLE, random_time_step());
        end
      end
    end

    // run of full time steps
    program_setpoints(random_setpoint(), random_setpoint(),
                      random_setpoint(), random_setpoint());
    send_request(cht_pkg::OP_LATCH, '0);
    repeat (RUNOUT_SAMPLES) send_request(cht_pkg::OP_SAMPLE, '1);

    // flat spline returns the start position exactly
    anchor = $urandom();
    program_setpoints(anchor, anchor, '0, '0);
    send_request(cht_pkg::OP_LATCH, '0);
    repeat (3) send_request(cht_pkg::OP_SAMPLE, random_time_step());
    program_setpoints(random_setpoint(), random_setpoint(),
                      random_setpoint(), random_setpoint());
    send_request(cht_pkg::OP_LATCH, '0);
    repeat (3) send_request(cht_pkg::OP_SAMPLE, random_time_step());

    item_valid <= 1'b0;
    wait_drained();
    if (failures == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
